// ----- src/cordic_pkg.sv -----
// Shared widths, constants, types and the arctangent table for the CORDIC sine/cosine unit.
package cordic_pkg;

  localparam int unsigned IterationsDefault = 26;
  localparam int unsigned RomDepth          = 40;
  localparam int unsigned RomIdxW           = 6;
  localparam int unsigned DataW             = 64;
  localparam int unsigned AngleW            = 62;
  localparam int unsigned OctW              = 3;
  localparam int unsigned ResW              = 32;

  // 1/K gain compensation, Q2.62
  localparam logic [DataW-1:0] XStart = 64'h26DD_3B6A_10D7_969A;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_RUN    = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  typedef enum logic [OctW-1:0] {
    OCT_0 = 3'd0,
    OCT_1 = 3'd1,
    OCT_2 = 3'd2,
    OCT_3 = 3'd3,
    OCT_4 = 3'd4,
    OCT_5 = 3'd5,
    OCT_6 = 3'd6,
    OCT_7 = 3'd7
  } octant_e;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic last_iter;
  } dp_status_t;

  // atan(2^-i) in Q2.62
  function automatic logic [DataW-1:0] atan_rom(input logic [RomIdxW-1:0] idx);
    logic [DataW-1:0] v;
    case (idx)
      6'd0:  v = 64'h3243F6A8885A3000;
      6'd1:  v = 64'h1DAC670561BB4F00;
      6'd2:  v = 64'h0FADBAFC96406E80;
      6'd3:  v = 64'h07F56EA6AB0BDB80;
      6'd4:  v = 64'h03FEAB76E59FBD40;
      6'd5:  v = 64'h01FFD55BBA976250;
      6'd6:  v = 64'h00FFFAAADDDB94D8;
      6'd7:  v = 64'h007FFF5556EEEA5C;
      6'd8:  v = 64'h003FFFEAAAB7776E;
      6'd9:  v = 64'h001FFFFD5555BBBC;
      6'd10: v = 64'h000FFFFFAAAAADDE;
      6'd11: v = 64'h0007FFFFF555556F;
      6'd12: v = 64'h0003FFFFFEAAAAAC;
      6'd13: v = 64'h0001FFFFFFD55555;
      6'd14: v = 64'h0000FFFFFFFAAAAB;
      6'd15: v = 64'h00007FFFFFFF5555;
      6'd16: v = 64'h00003FFFFFFFEAAB;
      6'd17: v = 64'h00001FFFFFFFFD55;
      6'd18: v = 64'h00000FFFFFFFFFAB;
      6'd19: v = 64'h000007FFFFFFFFF5;
      6'd20: v = 64'h000003FFFFFFFFFE;
      6'd21: v = 64'h000001FFFFFFFFFF;
      6'd22: v = 64'h000000FFFFFFFFFF;
      6'd23: v = 64'h0000007FFFFFFFFF;
      6'd24: v = 64'h0000003FFFFFFFFF;
      6'd25: v = 64'h0000001FFFFFFFFF;
      6'd26: v = 64'h0000001000000000;
      6'd27: v = 64'h0000000800000000;
      6'd28: v = 64'h0000000400000000;
      6'd29: v = 64'h0000000200000000;
      6'd30: v = 64'h0000000100000000;
      6'd31: v = 64'h0000000080000000;
      6'd32: v = 64'h0000000040000000;
      6'd33: v = 64'h0000000020000000;
      6'd34: v = 64'h0000000010000000;
      6'd35: v = 64'h0000000008000000;
      6'd36: v = 64'h0000000004000000;
      6'd37: v = 64'h0000000002000000;
      6'd38: v = 64'h0000000001000000;
      6'd39: v = 64'h0000000000800000;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q2.62 -> Q2.30, round to nearest, ties to even, wrapping carry
  function automatic logic [ResW-1:0] round_q230(input logic [DataW-1:0] v);
    logic [ResW-1:0] h;
    logic [ResW-1:0] u;
    logic            inc;
    h   = v[DataW-1:ResW];
    u   = v[ResW-1:0];
    inc = u[ResW-1] & ((|u[ResW-2:0]) | h[0]);
    return h + {{(ResW-1){1'b0}}, inc};
  endfunction

endpackage

// ----- src/cordic_in_if.sv -----
// Request channel: reduced angle and octant index.
interface cordic_in_if;
  logic                              valid;
  logic                              ready;
  logic [cordic_pkg::AngleW-1:0]     angle;
  logic [cordic_pkg::OctW-1:0]       octant;

  modport source (output valid, angle, octant, input ready);
  modport sink   (input valid, angle, octant, output ready);
endinterface

// ----- src/cordic_out_if.sv -----
// Response channel: sine and cosine in Q2.30.
interface cordic_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [cordic_pkg::ResW-1:0] sine;
  logic signed [cordic_pkg::ResW-1:0] cosine;

  modport source (output valid, sine, cosine, input ready);
  modport sink   (input valid, sine, cosine, output ready);
endinterface

// ----- src/cordic_sine_cosine_octant_unit.sv -----
// Top level of the CORDIC sine/cosine unit with octant mapping.
//
// req_i carries one request: angle (Q2.62, first octant) and octant index.
// rsp_o returns sine and cosine in Q2.30 for each request, in order.
// Both channels use valid/ready; a transfer happens when both are high.
//
// One request is in flight at a time. After acceptance the unit runs
// ITERATIONS shift-add rotation steps (one iteration per cycle through
// 64-bit barrel shifts and add/subtract on x, y and z), then rounds and
// maps the octant into the output register. The unit takes a new request
// only after the last result has been written to the output register.
//
// The output register holds a finished result while the receiver stalls;
// the unit still takes and computes the next request, and waits in its
// final step until the output register is free.
// Reset clears the sequencer and the output valid; no result is pending.
module cordic_sine_cosine_octant_unit #(
  parameter int unsigned ITERATIONS = cordic_pkg::IterationsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cordic_in_if.sink   req_i,
  cordic_out_if.source rsp_o
);

  cordic_pkg::dp_cmd_t    cmd;
  cordic_pkg::dp_status_t status;

  cordic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cordic_dp #(
    .ITERATIONS (ITERATIONS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .angle_i  (req_i.angle),
    .octant_i (req_i.octant),
    .sine_o   (rsp_o.sine),
    .cosine_o (rsp_o.cosine)
  );

endmodule

// ----- src/cordic_ctrl.sv -----
// Sequencer for the CORDIC datapath: accept, iterate, round into the output register.
module cordic_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  cordic_pkg::dp_status_t status_i,
  output cordic_pkg::dp_cmd_t    cmd_o
);

  cordic_pkg::state_e state_q, state_d;
  logic               out_valid_q, out_valid_d;
  logic               accept;
  logic               emit;

  assign in_ready_o = (state_q == cordic_pkg::S_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  // output register free, or being drained this cycle
  assign emit       = (state_q == cordic_pkg::S_FINISH) & (~out_valid_q | out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cordic_pkg::S_IDLE: begin
        if (accept) state_d = cordic_pkg::S_RUN;
      end
      cordic_pkg::S_RUN: begin
        if (status_i.last_iter) state_d = cordic_pkg::S_FINISH;
      end
      cordic_pkg::S_FINISH: begin
        if (emit) state_d = cordic_pkg::S_IDLE;
      end
      default: state_d = cordic_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cordic_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o.load  = accept;
  assign cmd_o.step  = (state_q == cordic_pkg::S_RUN);
  assign cmd_o.emit  = emit;

endmodule

// ----- src/cordic_dp.sv -----
// CORDIC x/y/z registers with one shift-add rotation per cycle, rounding and octant mapping.
module cordic_dp #(
  parameter int unsigned ITERATIONS = cordic_pkg::IterationsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cordic_pkg::dp_cmd_t               cmd_i,
  output cordic_pkg::dp_status_t            status_o,
  input  logic [cordic_pkg::AngleW-1:0]     angle_i,
  input  logic [cordic_pkg::OctW-1:0]       octant_i,
  output logic signed [cordic_pkg::ResW-1:0] sine_o,
  output logic signed [cordic_pkg::ResW-1:0] cosine_o
);

  localparam int unsigned IterW = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;
  localparam int unsigned DataW = cordic_pkg::DataW;
  localparam int unsigned ResW  = cordic_pkg::ResW;

  logic signed [DataW-1:0]          x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [DataW-1:0]          x_sh, y_sh;
  logic [DataW-1:0]                 atan_val;
  logic [cordic_pkg::OctW-1:0]      oct_q, oct_d;
  logic [IterW-1:0]                 cnt_q, cnt_d;
  logic [ResW-1:0]                  s_rnd, c_rnd, s_neg, c_neg;
  logic [ResW-1:0]                  sine_q, sine_d, cosine_q, cosine_d;

  assign x_sh     = x_q >>> cnt_q;
  assign y_sh     = y_q >>> cnt_q;
  assign atan_val = cordic_pkg::atan_rom(cordic_pkg::RomIdxW'(cnt_q));

  assign status_o.last_iter = (cnt_q == IterW'(ITERATIONS - 1));

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    z_d   = z_q;
    oct_d = oct_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      x_d   = cordic_pkg::XStart;
      y_d   = '0;
      z_d   = {2'b00, angle_i};
      oct_d = octant_i;
      cnt_d = '0;
    end else if (cmd_i.step) begin
      // negative residual angle rotates clockwise
      if (z_q[DataW-1]) begin
        x_d = x_q + y_sh;
        y_d = y_q - x_sh;
        z_d = z_q + atan_val;
      end else begin
        x_d = x_q - y_sh;
        y_d = y_q + x_sh;
        z_d = z_q - atan_val;
      end
      cnt_d = cnt_q + 1'b1;
    end
  end

  assign c_rnd = cordic_pkg::round_q230(x_q);
  assign s_rnd = cordic_pkg::round_q230(y_q);
  assign c_neg = '0 - c_rnd;
  assign s_neg = '0 - s_rnd;

  always_comb begin
    sine_d   = sine_q;
    cosine_d = cosine_q;
    if (cmd_i.emit) begin
      case (cordic_pkg::octant_e'(oct_q))
        cordic_pkg::OCT_0: begin sine_d = s_rnd; cosine_d = c_rnd; end
        cordic_pkg::OCT_1: begin sine_d = c_rnd; cosine_d = s_rnd; end
        cordic_pkg::OCT_2: begin sine_d = c_rnd; cosine_d = s_neg; end
        cordic_pkg::OCT_3: begin sine_d = s_rnd; cosine_d = c_neg; end
        cordic_pkg::OCT_4: begin sine_d = s_neg; cosine_d = c_neg; end
        cordic_pkg::OCT_5: begin sine_d = c_neg; cosine_d = s_neg; end
        cordic_pkg::OCT_6: begin sine_d = c_neg; cosine_d = s_rnd; end
        default:           begin sine_d = s_neg; cosine_d = c_rnd; end
      endcase
    end
  end

  // counter is control; everything else is payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    z_q      <= z_d;
    oct_q    <= oct_d;
    sine_q   <= sine_d;
    cosine_q <= cosine_d;
  end

  assign sine_o   = sine_q;
  assign cosine_o = cosine_q;

endmodule

// ----- src/cordic_checker.sv -----
// Port-level checks for the CORDIC sine/cosine unit, bound to the top level.
module cordic_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [cordic_pkg::ResW-1:0]     sine_i,
  input logic [cordic_pkg::ResW-1:0]     cosine_i
);

  // a stalled response holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(sine_i) && $stable(cosine_i))
    else $error("stalled response changed");

  // one request in flight: no new request right after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i ##1 !in_ready_i)
    else $error("request accepted while busy");

  // a new response only appears while the unit is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("response without a request in flight");

  // no response rises right after a request is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !out_valid_i || !$rose(out_valid_i))
    else $error("response too soon after request");

endmodule

bind cordic_sine_cosine_octant_unit cordic_checker u_cordic_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .sine_i      (rsp_o.sine),
  .cosine_i    (rsp_o.cosine)
);
